FILE: sv/qrs_pkg.sv
`timescale 1ns / 1ps
// qrs_pkg: shared types and constants for the quadratic root solver.
// No dependencies.
package qrs_pkg;

    // Width of the near-zero threshold register
    localparam int THR_WIDTH = 16;

    // Result kind codes
    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_ALL     = 3'd1,
        KIND_LINEAR  = 3'd2,
        KIND_TWO     = 3'd3,
        KIND_DOUBLE  = 3'd4,
        KIND_COMPLEX = 3'd5
    } root_kind_t;

endpackage

FILE: sv/qrs_sqrt.sv
`timescale 1ns / 1ps
// qrs_sqrt: pipelined integer square root, one root bit per stage.
// Standalone; no package needed.
module qrs_sqrt #(
    parameter int RW = 33
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   radicand,
    output logic              out_valid,
    output logic [RW-1:0]     root
);

    localparam int RMW = RW + 2;

    logic [2*RW-1:0] rad_s  [RW+1];
    logic [RMW-1:0]  rem_s  [RW+1];
    logic [RW-1:0]   root_s [RW+1];
    logic            v_s    [RW+1];

    // stage 0 is the input
    assign rad_s[0]  = radicand;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign v_s[0]    = in_valid;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RMW-1:0]  rem_sh;
        logic [RMW-1:0]  trial;
        logic            ge;
        logic [RMW-1:0]  rem_next;
        logic [RW-1:0]   root_next;
        logic [2*RW-1:0] rad_next;
        logic [2*RW-1:0] rad_reg;
        logic [RMW-1:0]  rem_reg;
        logic [RW-1:0]   root_reg;
        logic            v_reg;

        // bring down two radicand bits, try root*4+1
        always_comb
        begin
            rem_sh    = {rem_s[k][RW-1:0], rad_s[k][2*RW-1:2*RW-2]};
            trial     = {root_s[k], 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_s[k][RW-2:0], ge};
            rad_next  = {rad_s[k][2*RW-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else
            begin
                v_reg <= v_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end

        assign rad_s[k+1]  = rad_reg;
        assign rem_s[k+1]  = rem_reg;
        assign root_s[k+1] = root_reg;
        assign v_s[k+1]    = v_reg;
    end

    assign out_valid = v_s[RW];
    assign root      = root_s[RW];

endmodule

FILE: sv/qrs_div.sv
`timescale 1ns / 1ps
// qrs_div: pipelined restoring divider, one quotient bit per stage.
// Standalone; no package needed.
module qrs_div #(
    parameter int NW   = 50,
    parameter int DENW = 33
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [NW-1:0]   num,
    input  logic [DENW-1:0] den,
    output logic            out_valid,
    output logic [NW-1:0]   quo
);

    logic [NW-1:0]   num_s [NW+1];
    logic [DENW-1:0] den_s [NW+1];
    logic [DENW-1:0] rem_s [NW+1];
    logic [NW-1:0]   quo_s [NW+1];
    logic            v_s   [NW+1];

    assign num_s[0] = num;
    assign den_s[0] = den;
    assign rem_s[0] = '0;
    assign quo_s[0] = '0;
    assign v_s[0]   = in_valid;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DENW:0]   rem_sh;
        logic [DENW:0]   diff;
        logic            ge;
        logic [DENW-1:0] rem_next;
        logic [NW-1:0]   num_reg;
        logic [DENW-1:0] den_reg;
        logic [DENW-1:0] rem_reg;
        logic [NW-1:0]   quo_reg;
        logic            v_reg;

        // shift in next numerator bit, subtract divisor if it fits
        always_comb
        begin
            rem_sh   = {rem_s[k], num_s[k][NW-1]};
            diff     = rem_sh - {1'b0, den_s[k]};
            ge       = (rem_sh >= {1'b0, den_s[k]});
            rem_next = ge ? diff[DENW-1:0] : rem_sh[DENW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else
            begin
                v_reg <= v_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg <= {num_s[k][NW-2:0], 1'b0};
            den_reg <= den_s[k];
            rem_reg <= rem_next;
            quo_reg <= {quo_s[k][NW-2:0], ge};
        end

        assign num_s[k+1] = num_reg;
        assign den_s[k+1] = den_reg;
        assign rem_s[k+1] = rem_reg;
        assign quo_s[k+1] = quo_reg;
        assign v_s[k+1]   = v_reg;
    end

    assign out_valid = v_s[NW];
    assign quo       = quo_s[NW];

endmodule

FILE: sv/quadratic_root_solver.sv
`timescale 1ns / 1ps
// quadratic_root_solver: roots of a*x^2+b*x+c=0 in signed fixed point.
// A result passes through front stages A to D, the bit-per-stage square root, stage E,
// the bit-per-stage divider pipelines and stage F.
// Throughput is one word per cycle; busy is never raised and results are never held off.
// Reset clears all valid bits and sets the threshold to 1; no clearing pass.
// Depends on qrs_pkg, qrs_sqrt, qrs_div.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] coef_a,
    input  logic signed [VALUE_WIDTH-1:0] coef_b,
    input  logic signed [VALUE_WIDTH-1:0] coef_c,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [THR_WIDTH-1:0]          cfg_data,
    output logic                          done,
    output logic [2:0]                    root_kind,
    output logic signed [VALUE_WIDTH-1:0] first_value,
    output logic signed [VALUE_WIDTH-1:0] second_value,
    output logic                          saturated
);

    localparam int W    = VALUE_WIDTH;
    localparam int RW   = W + 1;
    localparam int DW2  = 2 * RW;
    localparam int MW   = W + 2;
    localparam int NW   = MW + FRAC_BITS;
    localparam int DENW = W + 1;
    localparam int CMPW = DW2 + THR_WIDTH + FRAC_BITS;

    localparam logic [NW-1:0] HALF = NW'({1'b1, {(W-1){1'b0}}});

    typedef struct packed {
        root_kind_t   kind;
        logic         sa;
        logic         sb;
        logic         sc;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] mc;
    } sq_side_t;

    typedef struct packed {
        root_kind_t kind;
        logic       neg1;
        logic       neg2;
        logic       use1;
        logic       use2;
        logic       snap2;
    } dv_side_t;

    // Saturate, snap and encode one quotient: {sat, value}
    function automatic logic [W:0] finish_val(input logic [NW-1:0] q, input logic neg,
                                               input logic snap,
                                               input logic [THR_WIDTH-1:0] thr);
        logic [NW-1:0] limit;
        logic          sat;
        logic [W-1:0]  mag;
        limit = neg ? HALF : (HALF - NW'(1));
        sat   = (q > limit);
        mag   = sat ? limit[W-1:0] : q[W-1:0];
        if (snap && (mag < W'(thr)))
        begin
            mag = '0;
        end
        return {sat, (neg ? (~mag + 1'b1) : mag)};
    endfunction

    // threshold register
    logic [THR_WIDTH-1:0] thr_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_WIDTH'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // stage A: sign/magnitude decode and near-zero tests
    logic [W-1:0] ma_next, mb_next, mc_next;
    logic         za_next, zb_next, zc_next;
    logic         a_v_reg;
    sq_side_t     a_side_reg;
    logic         a_za_reg, a_zb_reg, a_zc_reg;

    always_comb
    begin
        ma_next = coef_a[W-1] ? (~coef_a + 1'b1) : coef_a;
        mb_next = coef_b[W-1] ? (~coef_b + 1'b1) : coef_b;
        mc_next = coef_c[W-1] ? (~coef_c + 1'b1) : coef_c;
        za_next = (ma_next < W'(thr_reg)) || (ma_next == '0);
        zb_next = (mb_next < W'(thr_reg)) || (mb_next == '0);
        zc_next = (mc_next < W'(thr_reg)) || (mc_next == '0);
    end

    always_ff @(posedge clk)
    begin
        a_side_reg.kind <= KIND_NONE;
        a_side_reg.sa   <= coef_a[W-1];
        a_side_reg.sb   <= coef_b[W-1];
        a_side_reg.sc   <= coef_c[W-1];
        a_side_reg.ma   <= ma_next;
        a_side_reg.mb   <= mb_next;
        a_side_reg.mc   <= mc_next;
        a_za_reg        <= za_next;
        a_zb_reg        <= zb_next;
        a_zc_reg        <= zc_next;
    end

    // stage B: products b*b and a*c
    logic [2*W-1:0] b_bb_reg, b_ac_reg;
    sq_side_t       b_side_reg;
    logic           b_za_reg, b_zb_reg, b_zc_reg;
    logic           b_v_reg;

    always_ff @(posedge clk)
    begin
        b_bb_reg   <= (2*W)'(a_side_reg.mb) * (2*W)'(a_side_reg.mb);
        b_ac_reg   <= (2*W)'(a_side_reg.ma) * (2*W)'(a_side_reg.mc);
        b_side_reg <= a_side_reg;
        b_za_reg   <= a_za_reg;
        b_zb_reg   <= a_zb_reg;
        b_zc_reg   <= a_zc_reg;
    end

    // stage C: discriminant as sign and magnitude
    logic [DW2-1:0] bbx, ac4;
    logic [DW2-1:0] dmag_next;
    logic           dneg_next;
    logic [DW2-1:0] c_dmag_reg;
    logic           c_dneg_reg;
    sq_side_t       c_side_reg;
    logic           c_za_reg, c_zb_reg, c_zc_reg;
    logic           c_v_reg;

    always_comb
    begin
        bbx = DW2'(b_bb_reg);
        ac4 = {b_ac_reg, 2'b00};
        if (b_side_reg.sa != b_side_reg.sc)
        begin
            dneg_next = 1'b0;
            dmag_next = bbx + ac4;
        end
        else if (bbx >= ac4)
        begin
            dneg_next = 1'b0;
            dmag_next = bbx - ac4;
        end
        else
        begin
            dneg_next = 1'b1;
            dmag_next = ac4 - bbx;
        end
    end

    always_ff @(posedge clk)
    begin
        c_dmag_reg <= dmag_next;
        c_dneg_reg <= dneg_next;
        c_side_reg <= b_side_reg;
        c_za_reg   <= b_za_reg;
        c_zb_reg   <= b_zb_reg;
        c_zc_reg   <= b_zc_reg;
    end

    // stage D: classify
    logic [CMPW-1:0] dcmp, thrd;
    root_kind_t      kind_next;
    logic [DW2-1:0]  d_dmag_reg;
    sq_side_t        d_side_reg;
    logic            d_v_reg;

    always_comb
    begin
        dcmp = CMPW'(c_dmag_reg);
        thrd = CMPW'(thr_reg) << FRAC_BITS;
        if (c_za_reg)
        begin
            if (c_zb_reg)
            begin
                kind_next = c_zc_reg ? KIND_ALL : KIND_NONE;
            end
            else
            begin
                kind_next = KIND_LINEAR;
            end
        end
        else if (!c_dneg_reg && (dcmp > thrd))
        begin
            kind_next = KIND_TWO;
        end
        else if (c_dneg_reg && !((dcmp < thrd) || (dcmp == '0)))
        begin
            kind_next = KIND_COMPLEX;
        end
        else
        begin
            kind_next = KIND_DOUBLE;
        end
    end

    always_ff @(posedge clk)
    begin
        d_dmag_reg <= c_dmag_reg;
        d_side_reg <= '{kind: kind_next, sa: c_side_reg.sa, sb: c_side_reg.sb,
                        sc: c_side_reg.sc, ma: c_side_reg.ma, mb: c_side_reg.mb,
                        mc: c_side_reg.mc};
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= start && !busy;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    // square root of |D|, with side data delayed alongside
    logic          sq_v;
    logic [RW-1:0] sq_root;
    sq_side_t      sq_line [RW+1];

    qrs_sqrt #(
        .RW(RW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d_v_reg),
        .radicand (d_dmag_reg),
        .out_valid(sq_v),
        .root     (sq_root)
    );

    assign sq_line[0] = d_side_reg;
    for (genvar k = 0; k < RW; k++) begin : g_sq_line
        sq_side_t line_reg;
        always_ff @(posedge clk)
        begin
            line_reg <= sq_line[k];
        end
        assign sq_line[k+1] = line_reg;
    end

    // stage E: numerators, divisor and signs for the dividers
    sq_side_t              es;
    logic signed [W+2:0]   mbx, sx, negb, x1, x2;
    logic [MW-1:0]         num1_next, num2_next;
    logic [DENW-1:0]       den_next;
    dv_side_t              eside_next;
    logic [MW-1:0]         e_num1_reg, e_num2_reg;
    logic [DENW-1:0]       e_den_reg;
    dv_side_t              e_side_reg;
    logic                  e_v_reg;

    always_comb
    begin
        es         = sq_line[RW];
        mbx        = signed'({3'b000, es.mb});
        sx         = signed'({2'b00, sq_root});
        negb       = es.sb ? mbx : -mbx;
        x1         = negb + sx;
        x2         = negb - sx;
        num1_next  = '0;
        num2_next  = '0;
        den_next   = {es.ma, 1'b0};
        eside_next = '{kind: es.kind, neg1: 1'b0, neg2: 1'b0, use1: 1'b0, use2: 1'b0,
                       snap2: 1'b1};
        case (es.kind)
            KIND_LINEAR:
            begin
                num1_next       = MW'(es.mc);
                den_next        = {1'b0, es.mb};
                eside_next.neg1 = (!es.sc) != es.sb;
                eside_next.use1 = 1'b1;
            end
            KIND_TWO:
            begin
                num1_next       = x1[W+2] ? MW'(-x1) : MW'(x1);
                num2_next       = x2[W+2] ? MW'(-x2) : MW'(x2);
                eside_next.neg1 = x1[W+2] != es.sa;
                eside_next.neg2 = x2[W+2] != es.sa;
                eside_next.use1 = 1'b1;
                eside_next.use2 = 1'b1;
            end
            KIND_DOUBLE:
            begin
                num1_next       = MW'(es.mb);
                eside_next.neg1 = (!es.sb) != es.sa;
                eside_next.use1 = 1'b1;
            end
            KIND_COMPLEX:
            begin
                num1_next        = MW'(es.mb);
                num2_next        = MW'(sq_root);
                eside_next.neg1  = (!es.sb) != es.sa;
                eside_next.use1  = 1'b1;
                eside_next.use2  = 1'b1;
                eside_next.snap2 = 1'b0;
            end
            default:
            begin
                num1_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        e_num1_reg <= num1_next;
        e_num2_reg <= num2_next;
        e_den_reg  <= den_next;
        e_side_reg <= eside_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else
        begin
            e_v_reg <= sq_v;
        end
    end

    // two dividers, side data delayed alongside
    logic          dv1_v, dv2_v;
    logic [NW-1:0] q1, q2;
    dv_side_t      dv_line [NW+1];

    qrs_div #(
        .NW  (NW),
        .DENW(DENW)
    ) u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (e_v_reg),
        .num      ({e_num1_reg, {FRAC_BITS{1'b0}}}),
        .den      (e_den_reg),
        .out_valid(dv1_v),
        .quo      (q1)
    );

    qrs_div #(
        .NW  (NW),
        .DENW(DENW)
    ) u_div2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (e_v_reg),
        .num      ({e_num2_reg, {FRAC_BITS{1'b0}}}),
        .den      (e_den_reg),
        .out_valid(dv2_v),
        .quo      (q2)
    );

    assign dv_line[0] = e_side_reg;
    for (genvar k = 0; k < NW; k++) begin : g_dv_line
        dv_side_t line_reg;
        always_ff @(posedge clk)
        begin
            line_reg <= dv_line[k];
        end
        assign dv_line[k+1] = line_reg;
    end

    // stage F: saturate, snap, encode into the output word
    dv_side_t     fs;
    logic [W:0]   f1, f2;
    logic         done_reg;
    root_kind_t   kind_reg;
    logic [W-1:0] first_reg, second_reg;
    logic         sat_reg;

    always_comb
    begin
        fs = dv_line[NW];
        f1 = finish_val(q1, fs.neg1, 1'b1, thr_reg);
        f2 = finish_val(q2, fs.neg2, fs.snap2, thr_reg);
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= fs.kind;
        first_reg  <= fs.use1 ? f1[W-1:0] : '0;
        second_reg <= fs.use2 ? f2[W-1:0] : '0;
        sat_reg    <= (fs.use1 && f1[W]) || (fs.use2 && f2[W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv1_v && dv2_v;
        end
    end

    assign done         = done_reg;
    assign root_kind    = kind_reg;
    assign first_value  = signed'(first_reg);
    assign second_value = signed'(second_reg);
    assign saturated    = sat_reg;

endmodule

FILE: bench/quadratic_root_solver_checker.sv
`timescale 1ns / 1ps
// quadratic_root_solver_checker: watches the coefficient, threshold and result channels,
// predicts each result word from the accepted coefficients and compares it field by field.
// Depends on qrs_pkg.
module quadratic_root_solver_checker
    import qrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic signed [31:0]   coef_a,
    input  logic signed [31:0]   coef_b,
    input  logic signed [31:0]   coef_c,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [THR_WIDTH-1:0] cfg_data,
    input  logic                 done,
    input  logic [2:0]           root_kind,
    input  logic signed [31:0]   first_value,
    input  logic signed [31:0]   second_value,
    input  logic                 saturated,
    output int                   fail_count,
    output int                   roots_pending,
    output int                   roots_checked
);

    typedef struct packed {
        root_kind_t  kind;
        logic [31:0] v1;
        logic [31:0] v2;
        logic        sat;
    } roots_t;

    roots_t         expected_roots[$];
    logic [15:0]    threshold;

    // magnitude of a two's complement word, -2^31 giving 2^31
    function automatic logic [127:0] magnitude(input logic [31:0] x);
        logic [32:0] m;
        m = x[31] ? -{x[31], x} : {1'b0, x};
        return {95'd0, m};
    endfunction

    function automatic bit near_zero(input logic [127:0] mag, input logic [127:0] thr);
        return (mag < thr) || (mag == 0);
    endfunction

    // (num << 16) / den truncated, clamped, optionally snapped; bit 32 is the clamp flag
    function automatic logic [32:0] scale_root(input bit neg, input logic [127:0] num,
                                               input logic [127:0] den, input bit snap,
                                               input logic [15:0] thr);
        logic [127:0] q;
        logic [127:0] lim;
        logic [127:0] mag;
        bit           clamp;
        q     = (num << 16) / den;
        lim   = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        clamp = q > lim;
        mag   = clamp ? lim : q;
        if (snap && mag < {112'd0, thr})
            mag = 0;
        return {clamp, neg ? -mag[31:0] : mag[31:0]};
    endfunction

    function automatic logic [127:0] isqrt(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int i = 40; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic roots_t solve_roots(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [15:0] thr);
        roots_t       r;
        logic [127:0] ma, mb, mc, bb, ac4, dmag, thr_d, den, s, m;
        logic [32:0]  q;
        bit           sa, sb, sc, dneg, n;
        sa = a[31]; sb = b[31]; sc = c[31];
        ma = magnitude(a); mb = magnitude(b); mc = magnitude(c);
        r = '{KIND_NONE, 32'd0, 32'd0, 1'b0};
        if (near_zero(ma, {112'd0, thr}))
        begin
            if (near_zero(mb, {112'd0, thr}))
                r.kind = near_zero(mc, {112'd0, thr}) ? KIND_ALL : KIND_NONE;
            else
            begin
                r.kind = KIND_LINEAR;
                q = scale_root((!sc) != sb, mc, mb, 1'b1, thr);
                r.v1 = q[31:0]; r.sat = q[32];
            end
        end
        else
        begin
            bb    = mb * mb;
            ac4   = (ma * mc) << 2;
            thr_d = {112'd0, thr} << 16;
            den   = ma << 1;
            if (sa != sc)        begin dneg = 0; dmag = bb + ac4; end
            else if (bb >= ac4)  begin dneg = 0; dmag = bb - ac4; end
            else                 begin dneg = 1; dmag = ac4 - bb; end
            if (!dneg && dmag > thr_d)
            begin
                r.kind = KIND_TWO;
                s = isqrt(dmag);
                // -b + sqrt(D)
                if (!sb) begin n = (s > mb) ? 0 : 1; m = (s > mb) ? s - mb : mb - s; end
                else     begin n = 0; m = mb + s; end
                q = scale_root(n != sa, m, den, 1'b1, thr);
                r.v1 = q[31:0]; r.sat = q[32];
                // -b - sqrt(D)
                if (sb)  begin n = (s > mb) ? 1 : 0; m = (s > mb) ? s - mb : mb - s; end
                else     begin n = 1; m = mb + s; end
                q = scale_root(n != sa, m, den, 1'b1, thr);
                r.v2 = q[31:0]; r.sat = r.sat | q[32];
            end
            else
            begin
                r.kind = (dneg && !near_zero(dmag, thr_d)) ? KIND_COMPLEX : KIND_DOUBLE;
                q = scale_root((!sb) != sa, mb, den, 1'b1, thr);
                r.v1 = q[31:0]; r.sat = q[32];
                if (r.kind == KIND_COMPLEX)
                begin
                    // imaginary magnitude is never snapped
                    q = scale_root(1'b0, isqrt(dmag), den, 1'b0, thr);
                    r.v2 = q[31:0]; r.sat = r.sat | q[32];
                end
            end
        end
        return r;
    endfunction

    assign roots_pending = expected_roots.size();

    // threshold copy, predictions and comparisons
    always @(posedge clk or negedge rst_n)
    begin
        roots_t e;
        if (!rst_n)
        begin
            threshold = 16'd1;
            expected_roots.delete();
            fail_count    = 0;
            roots_checked = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_roots.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_roots.pop_front();
                    roots_checked++;
                    if (root_kind !== e.kind)
                    begin
                        $error("root_kind: expected %0d, got %0d", e.kind, root_kind);
                        fail_count++;
                    end
                    if (first_value !== e.v1)
                    begin
                        $error("first_value: expected %h, got %h", e.v1, first_value);
                        fail_count++;
                    end
                    if (second_value !== e.v2)
                    begin
                        $error("second_value: expected %h, got %h", e.v2, second_value);
                        fail_count++;
                    end
                    if (saturated !== e.sat)
                    begin
                        $error("saturated: expected %0b, got %0b", e.sat, saturated);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_roots.push_back(solve_roots(coef_a, coef_b, coef_c, threshold));
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
        end
    end

endmodule

FILE: bench/quadratic_root_solver_tb.sv
`timescale 1ns / 1ps
// quadratic_root_solver_tb: drives coefficient and threshold words into the solver
// and gives the verdict. Depends on qrs_pkg, quadratic_root_solver and its checker.
module quadratic_root_solver_tb;
    import qrs_pkg::*;

    localparam int LATENCY     = 89;
    localparam int CYCLE_LIMIT = 300000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [31:0]   coef_a, coef_b, coef_c;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [THR_WIDTH-1:0] cfg_data;
    logic                 done;
    logic [2:0]           root_kind;
    logic signed [31:0]   first_value, second_value;
    logic                 saturated;
    int                   fail_count, roots_pending, roots_checked;
    int                   cycles = 0;

    quadratic_root_solver dut (.*);
    quadratic_root_solver_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one coefficient word, after a random gap
    task automatic send_coefs(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start  <= 1'b1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // let every result arrive, then write the threshold
    task automatic set_threshold(input logic [15:0] thr);
        start <= 1'b0;
        while (roots_pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= thr;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
            2:       return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            3:       return 32'($signed($urandom_range(0, 8)) - 4);
            4:       return 32'd0;
            default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    task automatic random_items(input int count);
        logic [31:0] p, q;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // exact double root: a = p, b = 2pq, c = pq^2
                p = $urandom_range(1, 64);
                q = 32'($signed($urandom_range(0, 200)) - 100);
                send_coefs(p, 2 * p * q, p * q * q);
            end
            else
                send_coefs(rand_coef(), rand_coef(), rand_coef());
        end
    endtask

    logic [15:0] thresholds[5];

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        coef_a    = '0;
        coef_b    = '0;
        coef_c    = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: degenerate, linear, all kinds, extremes, saturation
        send_coefs(0, 0, 0);
        send_coefs(0, 0, 32'h0001_0000);
        send_coefs(0, 32'h0002_0000, 32'hfffc_0000);
        send_coefs(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
        send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_coefs(32'h0001_0000, 0, 32'h0001_0000);
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_coefs(0, 32'h0000_0001, 32'h7fff_ffff);
        send_coefs(0, 32'hffff_ffff, 32'h8000_0000);
        send_coefs(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0001);
        send_coefs(32'h0000_0002, 32'h0000_0004, 32'h0000_0002);
        send_coefs(32'hffff_ffff, 32'h0000_0001, 32'h0000_0000);
        send_coefs(32'h0001_0000, 32'h0000_0001, 32'h0000_0000);
        send_coefs(32'hffff_0000, 32'h0000_0000, 32'h0400_0000);
        send_coefs(32'h5555_aaaa, 32'haaaa_5555, 32'h0f0f_f0f0);

        // threshold sweep with random coefficients; each phase drains first
        thresholds = '{16'd0, 16'd65535, 16'($urandom_range(2, 65534)), 16'd256, 16'd1};
        foreach (thresholds[k])
        begin
            set_threshold(thresholds[k]);
            send_coefs(32'h0000_0001, 0, 32'hffff_ffff);
            send_coefs(0, 32'h0000_ffff, 32'h0001_0000);
            random_items(120);
        end

        start <= 1'b0;
        while (roots_pending != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("Checked %0d root words over six threshold settings incl. 0 and 65535.",
                 roots_checked);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
